### rtl/gsiu_pkg.sv
// Package for the 3D grid stencil index unit: field widths, codes and the
// structs passed between pipeline sections. No dependencies.
`default_nettype none

package gsiu_pkg;

	localparam int MAX_CELLS = 1024;

	localparam int DIM_W     = 11;
	localparam int POS_W     = 11;
	localparam int FLAT_W    = 31;
	localparam int PLANE_W   = 21;
	localparam int NB_W      = 32;
	localparam int LAYOUT_W  = 3;
	localparam int QUOT_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [LAYOUT_W-1:0] LAYOUT_CENTER = 3'd0;
	localparam logic [LAYOUT_W-1:0] LAYOUT_XFACE  = 3'd1;
	localparam logic [LAYOUT_W-1:0] LAYOUT_YFACE  = 3'd2;
	localparam logic [LAYOUT_W-1:0] LAYOUT_ZFACE  = 3'd3;
	localparam logic [LAYOUT_W-1:0] LAYOUT_NODE   = 3'd4;

	localparam logic CMD_SPLIT = 1'b0;
	localparam logic CMD_JOIN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT  = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0]    cells_x;
		logic [DIM_W-1:0]    cells_y;
		logic [DIM_W-1:0]    cells_z;
		logic [LAYOUT_W-1:0] layout;
	} gsiu_cfg_t;

	// item in flight; pos_* hold the fallback position until the dividers
	// fill them in for in-range items
	typedef struct packed {
		logic [FLAT_W-1:0]  flat;
		logic               ok;
		logic [DIM_W-1:0]   dx;
		logic [DIM_W-1:0]   dy;
		logic [DIM_W-1:0]   dz;
		logic [PLANE_W-1:0] dxy;
		logic [FLAT_W-1:0]  total;
		logic [POS_W-1:0]   pos_i;
		logic [POS_W-1:0]   pos_j;
		logic [POS_W-1:0]   pos_k;
	} gsiu_item_t;

	typedef struct packed {
		logic [FLAT_W-1:0]      flat_out;
		logic [POS_W-1:0]       out_i;
		logic [POS_W-1:0]       out_j;
		logic [POS_W-1:0]       out_k;
		logic signed [NB_W-1:0] west_nb;
		logic signed [NB_W-1:0] east_nb;
		logic signed [NB_W-1:0] south_nb;
		logic signed [NB_W-1:0] north_nb;
		logic signed [NB_W-1:0] below_nb;
		logic signed [NB_W-1:0] above_nb;
		logic [FLAT_W-1:0]      dof_total;
		logic                   in_range;
	} gsiu_res_t;

endpackage

`default_nettype wire

### rtl/grid3d_stencil_index_unit_core.sv
// Top level of the 3D grid stencil index unit: config registers, stream
// ports and the pipeline. Depends on gsiu_pkg, gsiu_prep, gsiu_div, gsiu_nbr.
//
//   channel   dir   handshake            carries
//   s_*       in    s_tvalid / s_tready  one query item (command in tuser)
//   m_*       out   m_tvalid / m_tready  one result item (in_range in tuser)
//   cfg_*     in    cfg_valid/cfg_ready  register index and write data
//
// One item per cycle sustained while m_tready is high; an item passes 17
// register stages: 4 prep stages, 6 of the k divider, 6 of the j divider and
// the output register. The first stage loads at the accepting edge, and
// m_tvalid rises when the item reaches the output register. Divider depth is set by two quotient bits per stage.
// Reset clears all valid bits and loads cells_* = 1, layout_q = 0.
// Every stage holds its item while the next one is full and stalled, and
// empty stages keep filling, so a stall on m_tready loses nothing.
`default_nettype none

module grid3d_stencil_index_unit_core import gsiu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// query stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // flat_in, pos_i, pos_j, pos_k
	input  logic                 s_tuser,   // command
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [287:0]         m_tdata,   // flat_out, out_i, out_j, out_k,
	                                        // west, east, south, north,
	                                        // below, above, dof_total, pad
	output logic                 m_tuser    // in_range
);

	// config registers; the user must write them only while the pipe is empty, the block does not enforce it
	logic [DIM_W-1:0]    cells_x_q, cells_y_q, cells_z_q;
	logic [LAYOUT_W-1:0] layout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= DIM_W'(1);
			cells_y_q <= DIM_W'(1);
			cells_z_q <= DIM_W'(1);
			layout_q  <= LAYOUT_CENTER;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CELLS_X: cells_x_q <= cfg_data;
				REG_CELLS_Y: cells_y_q <= cfg_data;
				REG_CELLS_Z: cells_z_q <= cfg_data;
				REG_LAYOUT:  layout_q  <= cfg_data[LAYOUT_W-1:0];
			endcase
		end
	end

	gsiu_cfg_t cfg;
	assign cfg.cells_x = cells_x_q;
	assign cfg.cells_y = cells_y_q;
	assign cfg.cells_z = cells_z_q;
	assign cfg.layout  = layout_q;

	// prep: dims, sizes, compose, range check
	logic       prep_valid, prep_ready;
	gsiu_item_t prep_item;

	gsiu_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_flat   (s_tdata[30:0]),
		.in_pos_i  (s_tdata[41:31]),
		.in_pos_j  (s_tdata[52:42]),
		.in_pos_k  (s_tdata[63:53]),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_item  (prep_item)
	);

	// k = flat / dxy, remainder goes on to the j divider
	logic              kdiv_valid, kdiv_ready;
	gsiu_item_t        kdiv_item, mid_item;
	logic [QUOT_W-1:0] kdiv_quot;
	logic [FLAT_W-1:0] kdiv_rem;

	gsiu_div u_kdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (prep_valid),
		.in_ready    (prep_ready),
		.in_item     (prep_item),
		.in_dividend (prep_item.flat),
		.in_divisor  (prep_item.dxy),
		.out_valid   (kdiv_valid),
		.out_ready   (kdiv_ready),
		.out_item    (kdiv_item),
		.out_quot    (kdiv_quot),
		.out_rem     (kdiv_rem)
	);

	// out-of-range items keep their fallback k
	always_comb begin
		mid_item = kdiv_item;
		if (kdiv_item.ok) mid_item.pos_k = kdiv_quot;
	end

	// j = rem / dx, i = rem % dx
	logic              jdiv_valid, jdiv_ready;
	gsiu_item_t        jdiv_item;
	logic [QUOT_W-1:0] jdiv_quot;
	logic [FLAT_W-1:0] jdiv_rem;

	gsiu_div u_jdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (kdiv_valid),
		.in_ready    (kdiv_ready),
		.in_item     (mid_item),
		.in_dividend (kdiv_rem),
		.in_divisor  (PLANE_W'(mid_item.dx)),
		.out_valid   (jdiv_valid),
		.out_ready   (jdiv_ready),
		.out_item    (jdiv_item),
		.out_quot    (jdiv_quot),
		.out_rem     (jdiv_rem)
	);

	// neighbors and output register
	gsiu_res_t res;

	gsiu_nbr u_nbr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (jdiv_valid),
		.in_ready  (jdiv_ready),
		.in_item   (jdiv_item),
		.in_quot   (jdiv_quot),
		.in_rem    (jdiv_rem),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.dof_total,
		res.above_nb, res.below_nb, res.north_nb, res.south_nb,
		res.east_nb, res.west_nb,
		res.out_k, res.out_j, res.out_i, res.flat_out};
	assign m_tuser = res.in_range;

endmodule

`default_nettype wire

### rtl/gsiu_prep.sv
// Front section: grid dims, plane and total sizes, compose of i/j/k and
// range checks over four pipeline stages. Depends on gsiu_pkg.
`default_nettype none

module gsiu_prep import gsiu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gsiu_cfg_t         cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_cmd,
	input  logic [FLAT_W-1:0] in_flat,
	input  logic [POS_W-1:0]  in_pos_i,
	input  logic [POS_W-1:0]  in_pos_j,
	input  logic [POS_W-1:0]  in_pos_k,
	output logic              out_valid,
	input  logic              out_ready,
	output gsiu_item_t        out_item
);

	localparam int JDX_W = 2 * DIM_W;

	function automatic logic [DIM_W-1:0] clamp_cells(input logic [DIM_W-1:0] c);
		logic [DIM_W-1:0] r;
		if (c == '0) begin
			r = DIM_W'(1);
		end else if (c > DIM_W'(MAX_CELLS)) begin
			r = DIM_W'(MAX_CELLS);
		end else begin
			r = c;
		end
		return r;
	endfunction

	logic [DIM_W-1:0] dx_c, dy_c, dz_c;

	always_comb begin
		dx_c = clamp_cells(cfg.cells_x);
		dy_c = clamp_cells(cfg.cells_y);
		dz_c = clamp_cells(cfg.cells_z);
		unique case (cfg.layout)
			LAYOUT_CENTER: ;
			LAYOUT_XFACE:  dx_c = dx_c + DIM_W'(1);
			LAYOUT_YFACE:  dy_c = dy_c + DIM_W'(1);
			LAYOUT_ZFACE:  dz_c = dz_c + DIM_W'(1);
			LAYOUT_NODE: begin
				dx_c = dx_c + DIM_W'(1);
				dy_c = dy_c + DIM_W'(1);
				dz_c = dz_c + DIM_W'(1);
			end
			default: ;   // unused codes act as cell center
		endcase
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: capture item and dims
	logic              cmd_s1;
	logic [FLAT_W-1:0] flat_s1;
	logic [POS_W-1:0]  pi_s1, pj_s1, pk_s1;
	logic [DIM_W-1:0]  dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			cmd_s1  <= in_cmd;
			flat_s1 <= in_flat;
			pi_s1   <= in_pos_i;
			pj_s1   <= in_pos_j;
			pk_s1   <= in_pos_k;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			dz_s1   <= dz_c;
		end
	end

	// stage 2: dx*dy, j*dx, compose range check
	logic               cmd_s2;
	logic [FLAT_W-1:0]  flat_s2;
	logic [POS_W-1:0]   pi_s2, pj_s2, pk_s2;
	logic [DIM_W-1:0]   dx_s2, dy_s2, dz_s2;
	logic [PLANE_W-1:0] dxy_s2;
	logic [JDX_W-1:0]   jdx_s2;
	logic               okj_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cmd_s2  <= cmd_s1;
			flat_s2 <= flat_s1;
			pi_s2   <= pi_s1;
			pj_s2   <= pj_s1;
			pk_s2   <= pk_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dz_s2   <= dz_s1;
			dxy_s2  <= PLANE_W'(dx_s1) * PLANE_W'(dy_s1);
			jdx_s2  <= JDX_W'(pj_s1) * JDX_W'(dx_s1);
			okj_s2  <= (pi_s1 < dx_s1) && (pj_s1 < dy_s1) && (pk_s1 < dz_s1);
		end
	end

	// stage 3: total count, k*dxy, j*dx + i
	logic               cmd_s3;
	logic [FLAT_W-1:0]  flat_s3;
	logic [POS_W-1:0]   pi_s3, pj_s3, pk_s3;
	logic [DIM_W-1:0]   dx_s3, dy_s3, dz_s3;
	logic [PLANE_W-1:0] dxy_s3;
	logic [FLAT_W-1:0]  total_s3, kdxy_s3, ij_s3;
	logic               okj_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			cmd_s3   <= cmd_s2;
			flat_s3  <= flat_s2;
			pi_s3    <= pi_s2;
			pj_s3    <= pj_s2;
			pk_s3    <= pk_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			dz_s3    <= dz_s2;
			dxy_s3   <= dxy_s2;
			total_s3 <= FLAT_W'(dxy_s2) * FLAT_W'(dz_s2);
			kdxy_s3  <= FLAT_W'(pk_s2) * FLAT_W'(dxy_s2);
			ij_s3    <= FLAT_W'(jdx_s2) + FLAT_W'(pi_s2);
			okj_s3   <= okj_s2;
		end
	end

	// stage 4: final flat index and in-range flag per command
	gsiu_item_t item_c, item_s4;

	always_comb begin
		item_c.dx    = dx_s3;
		item_c.dy    = dy_s3;
		item_c.dz    = dz_s3;
		item_c.dxy   = dxy_s3;
		item_c.total = total_s3;
		if (cmd_s3 == CMD_JOIN) begin
			item_c.ok    = okj_s3;
			item_c.flat  = okj_s3 ? (kdxy_s3 + ij_s3) : '0;
			item_c.pos_i = pi_s3;
			item_c.pos_j = pj_s3;
			item_c.pos_k = pk_s3;
		end else begin
			item_c.ok    = flat_s3 < total_s3;
			item_c.flat  = flat_s3;
			item_c.pos_i = '0;
			item_c.pos_j = '0;
			item_c.pos_k = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			item_s4 <= item_c;
		end
	end

	assign out_valid = valid_s4;
	assign out_item  = item_s4;

endmodule

`default_nettype wire

### rtl/gsiu_div.sv
// Pipelined restoring divider, two quotient bits per stage, with the item
// riding alongside. Depends on gsiu_pkg.
`default_nettype none

module gsiu_div import gsiu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gsiu_item_t         in_item,
	input  logic [FLAT_W-1:0]  in_dividend,
	input  logic [PLANE_W-1:0] in_divisor,
	output logic               out_valid,
	input  logic               out_ready,
	output gsiu_item_t         out_item,
	output logic [QUOT_W-1:0]  out_quot,
	output logic [FLAT_W-1:0]  out_rem
);

	localparam int STEPS  = 2;
	localparam int STAGES = (QUOT_W + STEPS - 1) / STEPS;
	localparam int SH_W   = FLAT_W + 1;

	logic               valid_s   [STAGES];
	logic [FLAT_W-1:0]  rem_s     [STAGES];
	logic [QUOT_W-1:0]  quot_s    [STAGES];
	logic [PLANE_W-1:0] divisor_s [STAGES];
	gsiu_item_t         item_s    [STAGES];
	wire  [STAGES-1:0]  ready_s;

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		localparam int B0 = QUOT_W - 1 - STEPS * s;

		logic               v_in;
		logic [FLAT_W-1:0]  rem_in;
		logic [QUOT_W-1:0]  quot_in;
		logic [PLANE_W-1:0] dvs_in;
		gsiu_item_t         item_in;
		logic               nxt_ready;
		logic [FLAT_W-1:0]  rem_nx;
		logic [QUOT_W-1:0]  quot_nx;

		if (s == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = in_dividend;
			assign quot_in = '0;
			assign dvs_in  = in_divisor;
			assign item_in = in_item;
		end else begin : g_body
			assign v_in    = valid_s[s-1];
			assign rem_in  = rem_s[s-1];
			assign quot_in = quot_s[s-1];
			assign dvs_in  = divisor_s[s-1];
			assign item_in = item_s[s-1];
		end

		if (s == STAGES - 1) begin : g_tail
			assign nxt_ready = out_ready;
		end else begin : g_link
			assign nxt_ready = ready_s[s+1];
		end

		assign ready_s[s] = !valid_s[s] || nxt_ready;

		always_comb begin : p_step
			logic [SH_W-1:0] dsh;
			rem_nx  = rem_in;
			quot_nx = quot_in;
			dsh     = '0;
			for (int t = 0; t < STEPS; t++) begin
				if (B0 - t >= 0) begin
					dsh = SH_W'(dvs_in) << (B0 - t);
					if ({1'b0, rem_nx} >= dsh) begin
						rem_nx  = rem_nx - dsh[FLAT_W-1:0];
						quot_nx = quot_nx | (QUOT_W'(1) << (B0 - t));
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[s] <= 1'b0;
			end else if (ready_s[s]) begin
				valid_s[s] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ready_s[s] && v_in) begin
				rem_s[s]     <= rem_nx;
				quot_s[s]    <= quot_nx;
				divisor_s[s] <= dvs_in;
				item_s[s]    <= item_in;
			end
		end
	end

	assign in_ready  = ready_s[0];
	assign out_valid = valid_s[STAGES-1];
	assign out_item  = item_s[STAGES-1];
	assign out_quot  = quot_s[STAGES-1];
	assign out_rem   = rem_s[STAGES-1];

endmodule

`default_nettype wire

### rtl/gsiu_nbr.sv
// Back section: final position select, six neighbor indices and the output
// register. Depends on gsiu_pkg.
`default_nettype none

module gsiu_nbr import gsiu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gsiu_item_t        in_item,
	input  logic [QUOT_W-1:0] in_quot,
	input  logic [FLAT_W-1:0] in_rem,
	output logic              out_valid,
	input  logic              out_ready,
	output gsiu_res_t         out_res
);

	logic      valid_q;
	gsiu_res_t res_q, res_c;

	logic [POS_W-1:0] pi, pj, pk;
	logic [NB_W-1:0]  flat_w, dx_w, dxy_w;

	always_comb begin
		pi     = in_item.ok ? in_rem[POS_W-1:0] : in_item.pos_i;
		pj     = in_item.ok ? in_quot : in_item.pos_j;
		pk     = in_item.pos_k;
		flat_w = NB_W'(in_item.flat);
		dx_w   = NB_W'(in_item.dx);
		dxy_w  = NB_W'(in_item.dxy);

		res_c.flat_out  = in_item.flat;
		res_c.out_i     = pi;
		res_c.out_j     = pj;
		res_c.out_k     = pk;
		res_c.dof_total = in_item.total;
		res_c.in_range  = in_item.ok;
		res_c.west_nb   = '1;
		res_c.east_nb   = '1;
		res_c.south_nb  = '1;
		res_c.north_nb  = '1;
		res_c.below_nb  = '1;
		res_c.above_nb  = '1;
		if (in_item.ok) begin
			if (pi != '0) res_c.west_nb = flat_w - NB_W'(1);
			if ((POS_W+1)'(pi) + (POS_W+1)'(1) < (POS_W+1)'(in_item.dx))
				res_c.east_nb = flat_w + NB_W'(1);
			if (pj != '0) res_c.south_nb = flat_w - dx_w;
			if ((POS_W+1)'(pj) + (POS_W+1)'(1) < (POS_W+1)'(in_item.dy))
				res_c.north_nb = flat_w + dx_w;
			if (pk != '0) res_c.below_nb = flat_w - dxy_w;
			if ((POS_W+1)'(pk) + (POS_W+1)'(1) < (POS_W+1)'(in_item.dz))
				res_c.above_nb = flat_w + dxy_w;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= res_c;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire
